FILE: design/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

  // map word geometry
  localparam int WORD_SH = 5;
  localparam int WORD_W  = 1 << WORD_SH;

  // command codes
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // configuration register indexes
  localparam int         CFG_IDX_W = 1;
  localparam logic [0:0] REG_BASE  = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

  typedef struct packed {
    logic               found;
    logic [WORD_SH-1:0] pos;
  } scan_res_t;

  // bits of a map word whose page index lies below lim; base is the word's first page
  function automatic logic [WORD_W-1:0] lt_mask(input logic [31:0] lim,
                                                input logic [31:0] base);
    logic [31:0]       rel;
    logic [WORD_W-1:0] m;
    rel = lim - base;
    if (lim <= base) begin
      m = '0;
    end else if (rel >= 32'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << rel[WORD_SH-1:0]) - WORD_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: design/bpa_map_mem.sv
`default_nettype none

module bpa_map_mem import bpa_pkg::*; #(
  parameter int ROWS  = 32,
  parameter int ROW_W = 5
) (
  input  wire               clk_i,
  input  wire               we_i,
  input  wire  [ROW_W-1:0]  waddr_i,
  input  wire  [WORD_W-1:0] wdata_i,
  input  wire  [ROW_W-1:0]  raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/bpa_word_scan.sv
`default_nettype none

module bpa_word_scan import bpa_pkg::*; #(
  parameter int ROW_W = 5,
  parameter int N_W   = 11
) (
  input  wire  [WORD_W-1:0] word_i,
  input  wire  [ROW_W-1:0]  row_i,
  input  wire  [N_W-1:0]    lim_i,
  output scan_res_t         res_o
);

  // lowest clear bit among pages below the active count
  always_comb begin
    logic [WORD_W-1:0] avail;
    avail = ~word_i & lt_mask(32'(lim_i), 32'(row_i) << WORD_SH);
    res_o = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res_o.found = 1'b1;
        res_o.pos   = WORD_SH'(b);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/bitmap_page_allocator_top.sv
`default_nettype none

// first-fit page frame allocator over a used/free bitmap of MAX_PAGES pages,
// kept in a memory of 32-bit words. one command is taken per beat and each
// command returns exactly one result beat. after reset the block runs a
// clearing pass over every map word before it takes its first beat;
// configuration writes are taken at any time. an alloc scans the map one word
// per cycle through a single word scanner; an init rewrites every map word; a
// free is a read-modify-write of one word, and a free out of range or a nop
// goes straight to the result. the result sits in an output register, so the
// next command is taken while a result waits. PAGE_BYTES must be a power of two.
module bitmap_page_allocator_top import bpa_pkg::*; #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_BYTES = 4096
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration write port
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [31:0]          cfg_wdata_i,
  // command stream
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [39:0]          s_axis_tdata,   // command[1:0], free_address[33:2], zero pad
  // result stream
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [39:0]         m_axis_tdata    // page_address[31:0], success[32], zero pad
);

  localparam int ROWS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RC_W  = $clog2(ROWS + 1);
  localparam int N_W   = $clog2(MAX_PAGES + 1);
  localparam int PG_W  = ROW_W + WORD_SH;
  localparam int PB_SH = $clog2(PAGE_BYTES);

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SWEEP   = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_FREE_RD = 3'd3;
  localparam logic [2:0] ST_FREE_WR = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [RC_W-1:0]  row_q, row_d;
  logic [N_W-1:0]   lim_q, lim_d;
  logic             sweep_resp_q, sweep_resp_d;
  logic             chk_vld_q, chk_vld_d;
  logic [ROW_W-1:0] chk_row_q, chk_row_d;
  logic [PG_W-1:0]  pg_q, pg_d;
  logic [31:0]      res_addr_q, res_addr_d;
  logic             res_ok_q, res_ok_d;
  logic             out_vld_q, out_vld_d;
  logic [31:0]      out_addr_q, out_addr_d;
  logic             out_ok_q, out_ok_d;
  logic [31:0]      base_q;
  logic [10:0]      pcnt_q;

  // map memory port
  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ROW_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  scan_res_t scan;

  // command beat fields
  logic [1:0]  in_cmd;
  logic [31:0] in_addr;
  assign in_cmd  = s_axis_tdata[1:0];
  assign in_addr = s_axis_tdata[33:2];

  // active page count, saturated at the map size
  logic [N_W-1:0] n_pages;
  assign n_pages = (32'(pcnt_q) > 32'(MAX_PAGES)) ? N_W'(MAX_PAGES) : N_W'(pcnt_q);

  // map words that hold active pages
  logic [RC_W-1:0] rows_n;
  assign rows_n = RC_W'((32'(n_pages) + 32'(WORD_W - 1)) >> WORD_SH);

  // pages taken by a byte-packed software bitmap, clipped to the count
  logic [31:0]    map_pages;
  logic [N_W-1:0] reserve;
  assign map_pages = (((32'(n_pages) + 32'd7) >> 3) + 32'(PAGE_BYTES - 1)) >> PB_SH;
  assign reserve   = (map_pages < 32'(n_pages)) ? N_W'(map_pages) : n_pages;

  // free address decode
  logic [31:0] free_off;
  logic [31:0] free_idx;
  logic        free_ok;
  assign free_off = in_addr - base_q;
  assign free_idx = free_off >> PB_SH;
  assign free_ok  = (in_addr >= base_q) && (free_idx < 32'(n_pages));

  logic scan_issue;
  assign scan_issue = (row_q < rows_n);

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_ok_q, out_addr_q};

  bpa_map_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bpa_word_scan #(
    .ROW_W (ROW_W),
    .N_W   (N_W)
  ) u_scan (
    .word_i (mem_rdata),
    .row_i  (chk_row_q),
    .lim_i  (n_pages),
    .res_o  (scan)
  );

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    lim_d        = lim_q;
    sweep_resp_d = sweep_resp_q;
    chk_vld_d    = chk_vld_q;
    chk_row_d    = chk_row_q;
    pg_d         = pg_q;
    res_addr_d   = res_addr_q;
    res_ok_d     = res_ok_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_addr_d   = out_addr_q;
    out_ok_d     = out_ok_q;
    mem_we       = 1'b0;
    mem_waddr    = chk_row_q;
    mem_wdata    = mem_rdata;
    mem_raddr    = row_q[ROW_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_addr_d = '0;
          res_ok_d   = 1'b0;
          row_d      = '0;
          chk_vld_d  = 1'b0;
          unique case (in_cmd)
            CMD_INIT: begin
              lim_d        = reserve;
              sweep_resp_d = 1'b1;
              res_ok_d     = 1'b1;
              state_d      = ST_SWEEP;
            end
            CMD_ALLOC: begin
              state_d = ST_SCAN;
            end
            CMD_FREE: begin
              pg_d    = PG_W'(free_idx);
              state_d = free_ok ? ST_FREE_RD : ST_DONE;
            end
            CMD_NOP: begin
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // rewrite every map word: pages below lim_q used, the rest free
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = row_q[ROW_W-1:0];
        mem_wdata = lt_mask(32'(lim_q), 32'(row_q) << WORD_SH);
        row_d     = row_q + RC_W'(1);
        if (row_q == RC_W'(ROWS - 1)) begin
          row_d   = '0;
          state_d = sweep_resp_q ? ST_DONE : ST_IDLE;
        end
      end

      // one word read per cycle, checked in the cycle after its read
      ST_SCAN: begin
        row_d     = row_q + RC_W'(scan_issue);
        chk_vld_d = scan_issue;
        chk_row_d = row_q[ROW_W-1:0];
        if (chk_vld_q && scan.found) begin
          mem_we     = 1'b1;
          mem_waddr  = chk_row_q;
          mem_wdata  = mem_rdata | (WORD_W'(1) << scan.pos);
          res_addr_d = base_q + (32'({chk_row_q, scan.pos}) << PB_SH);
          res_ok_d   = 1'b1;
          chk_vld_d  = 1'b0;
          state_d    = ST_DONE;
        end else if (!chk_vld_q && !scan_issue) begin
          state_d = ST_DONE;
        end
      end

      ST_FREE_RD: begin
        mem_raddr = pg_q[PG_W-1:WORD_SH];
        state_d   = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pg_q[PG_W-1:WORD_SH];
        mem_wdata = mem_rdata & ~(WORD_W'(1) << pg_q[WORD_SH-1:0]);
        res_ok_d  = 1'b1;
        state_d   = ST_DONE;
      end

      // hand the result to the output register once it has room
      ST_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_addr_d = res_addr_q;
          out_ok_d   = res_ok_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // reset runs the clearing pass with no result
      state_q      <= ST_SWEEP;
      row_q        <= '0;
      lim_q        <= '0;
      sweep_resp_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
      base_q       <= '0;
      pcnt_q       <= '0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      lim_q        <= lim_d;
      sweep_resp_q <= sweep_resp_d;
      chk_vld_q    <= chk_vld_d;
      out_vld_q    <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE:  base_q <= cfg_wdata_i;
          REG_COUNT: pcnt_q <= cfg_wdata_i[10:0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_row_q  <= chk_row_d;
    pg_q       <= pg_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    out_addr_q <= out_addr_d;
    out_ok_q   <= out_ok_d;
  end

endmodule

`default_nettype wire

FILE: bench/tb_bitmap_page_allocator_top.sv
`default_nettype none

module tb_bitmap_page_allocator_top;
  import bpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_BYTES = 4096;
  // slowest command (full alloc scan or init) plus output register slack
  localparam int DRAIN_CYCLES = 64;
  // roughly 650 beats, stretched by heavy stalls
  localparam int CYCLE_LIMIT  = 500000;

  // one result beat as seen on the master side
  typedef struct packed {
    logic [31:0] page_address;
    logic        success;
  } page_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [31:0]          cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata  = '0;  // command[1:0], free_address[33:2], zero pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;        // page_address[31:0], success[32], zero pad

  // shadow of the allocator: registers and used/free bitmap
  logic [31:0]   region_base_q;
  logic [10:0]   page_count_q;
  bit            page_used_q [MAX_PAGES];
  // results predicted at command acceptance, oldest first
  page_result_t  pending_results_q [$];
  // addresses handed out by successful allocs, used to build well-formed frees
  logic [31:0]   granted_pages_q [$];

  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   error_cnt = 0;

  bitmap_page_allocator_top #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_cnt);
      $display("** bitmap_page_allocator_top: FAILED **");
      $finish;
    end
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // shadow model of one command: updates the bitmap and returns the result beat
  function automatic page_result_t predict_page_cmd(input logic [1:0]  cmd,
                                                    input logic [31:0] addr);
    page_result_t res;
    int unsigned  live_pages;
    int unsigned  map_bytes;
    int unsigned  map_pages;
    int unsigned  idx;
    logic [31:0]  offs;
    bit           found;
    res        = '0;
    found      = 1'b0;
    // counts above the map size behave as a full map
    live_pages = (32'(page_count_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(page_count_q);
    case (cmd)
      CMD_INIT: begin
        // reserve the pages a byte-packed software bitmap would occupy
        map_bytes = (live_pages + 7) / 8;
        map_pages = (map_bytes + PAGE_BYTES - 1) / PAGE_BYTES;
        for (int i = 0; i < MAX_PAGES; i++) begin
          page_used_q[i] = (i < map_pages) && (i < live_pages);
        end
        granted_pages_q.delete();
        res.success = 1'b1;
      end
      CMD_ALLOC: begin
        // first fit over the pages below the current count only
        for (int i = 0; i < live_pages; i++) begin
          if (!found && !page_used_q[i]) begin
            found            = 1'b1;
            page_used_q[i]   = 1'b1;
            res.page_address = region_base_q + 32'(i * PAGE_BYTES);
            res.success      = 1'b1;
          end
        end
        if (found) begin
          granted_pages_q.push_back(res.page_address);
        end
      end
      CMD_FREE: begin
        // below the base or past the count leaves the map alone
        if (addr >= region_base_q) begin
          offs = addr - region_base_q;
          idx  = offs / PAGE_BYTES;
          if (idx < live_pages) begin
            page_used_q[idx] = 1'b0;
            res.success      = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // compare every accepted result beat against the oldest prediction
  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results_q.size() == 0) begin
        error_cnt++;
        $display("%0t unexpected result beat: expected none, actual addr %h success %b",
                 $time, m_axis_tdata[31:0], m_axis_tdata[32]);
      end else begin
        want = pending_results_q.pop_front();
        if (m_axis_tdata[31:0] !== want.page_address) begin
          error_cnt++;
          $display("%0t page_address mismatch: expected %h, actual %h",
                   $time, want.page_address, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[32] !== want.success) begin
          error_cnt++;
          $display("%0t success mismatch: expected %b, actual %b",
                   $time, want.success, m_axis_tdata[32]);
        end
      end
    end
  end

  // register write; the task waits with write enable low before it returns, so write enable pulses stay apart
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_BASE) begin
      region_base_q = value;
    end else begin
      page_count_q = value[10:0];
    end
    granted_pages_q.delete();
    @(posedge clk_i);
  endtask

  // one command beat; tvalid stays high on return so back-to-back beats need no
  // extra edge, any caller that waits must go through wait_idle first
  task automatic send_page_cmd(input logic [1:0] cmd, input logic [31:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, addr, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    pending_results_q.push_back(predict_page_cmd(cmd, addr));
  endtask

  // drop tvalid and wait until every predicted result has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_region(input logic [31:0] base, input logic [10:0] count);
    wait_idle();
    write_reg(REG_BASE, base);
    write_reg(REG_COUNT, {21'b0, count});
  endtask

  // reset values: count 0 means nothing can be allocated or freed
  task automatic test_after_reset();
    send_page_cmd(CMD_ALLOC, 32'h0);
    send_page_cmd(CMD_FREE, 32'h0);
    send_page_cmd(CMD_NOP, 32'h0);
    send_page_cmd(CMD_INIT, 32'h0);
  endtask

  task automatic test_corner_cases();
    // small map at base 0: exhaust it, then hand out page 0 as address 0
    set_region(32'h0, 11'd4);
    send_page_cmd(CMD_INIT, 32'h0);
    repeat (4) send_page_cmd(CMD_ALLOC, 32'h0);
    send_page_cmd(CMD_FREE, 32'h0);
    send_page_cmd(CMD_ALLOC, 32'h0);
    // double free still reports success
    send_page_cmd(CMD_FREE, 32'h0000_1000);
    send_page_cmd(CMD_FREE, 32'h0000_1FFF);
    send_page_cmd(CMD_FREE, 32'h0000_4000);
    // grow the count without init: old bits stay, new pages become reachable
    set_region(32'h0, 11'd6);
    send_page_cmd(CMD_ALLOC, 32'h0);
    send_page_cmd(CMD_ALLOC, 32'h0);
    // top of the address space with an oversized count: addresses wrap to 0
    set_region(32'hFFFF_F000, 11'h7FF);
    send_page_cmd(CMD_INIT, 32'h0);
    send_page_cmd(CMD_ALLOC, 32'h0);
    send_page_cmd(CMD_FREE, 32'h0000_0000);
    send_page_cmd(CMD_FREE, 32'hFFFF_FFFF);
    // full map at an ordinary base: last page in range, one past it out
    set_region(32'h1000_0000, 11'd1024);
    send_page_cmd(CMD_FREE, 32'h0FFF_FFFF);
    send_page_cmd(CMD_INIT, 32'h0);
    send_page_cmd(CMD_FREE, 32'h103F_F000);
    send_page_cmd(CMD_FREE, 32'h1040_0000);
    send_page_cmd(CMD_NOP, 32'hFFFF_FFFF);
  endtask

  // random region; mostly small counts so allocs run dry often
  task automatic pick_region();
    logic [31:0] base;
    logic [10:0] count;
    case ($urandom_range(4))
      0:       base = 32'h0;
      1:       base = 32'hFFFF_FFFF;
      2:       base = $urandom & 32'hFFFF_F000;
      default: base = $urandom;
    endcase
    case ($urandom_range(19))
      0:          count = 11'd0;
      1:          count = 11'd1024;
      2:          count = 11'($urandom_range(2047, 1025));
      3, 4:       count = 11'($urandom_range(1023, 65));
      default:    count = 11'($urandom_range(64, 1));
    endcase
    set_region(base, count);
  endtask

  task automatic run_traffic(input int unsigned beats);
    int unsigned pick;
    int unsigned slot;
    int unsigned live_pages;
    logic [31:0] addr;
    for (int b = 0; b < beats; b++) begin
      live_pages = (32'(page_count_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                         : 32'(page_count_q);
      pick = $urandom_range(99);
      if (pick < 30 && granted_pages_q.size() != 0) begin
        // release a page that was handed out, anywhere inside it
        slot = $urandom_range(granted_pages_q.size() - 1);
        addr = granted_pages_q[slot] + 32'($urandom_range(PAGE_BYTES - 1));
        granted_pages_q.delete(slot);
        send_page_cmd(CMD_FREE, addr);
      end else if (pick < 40 && live_pages != 0) begin
        // any in-range page, used or not
        addr = region_base_q + 32'($urandom_range(live_pages - 1) * PAGE_BYTES)
               + 32'($urandom_range(PAGE_BYTES - 1));
        send_page_cmd(CMD_FREE, addr);
      end else if (pick < 47) begin
        send_page_cmd(CMD_INIT, $urandom);
      end else if (pick < 55) begin
        send_page_cmd(CMD_FREE, $urandom);
      end else if (pick < 60) begin
        send_page_cmd(CMD_NOP, $urandom);
      end else begin
        send_page_cmd(CMD_ALLOC, $urandom);
      end
    end
  endtask

  // each idling mix gets three regions, every region starts from a fresh init
  task automatic test_random_traffic();
    int unsigned tx_mix [4] = '{0, 64, 0, 17};
    int unsigned rx_mix [4] = '{0, 0, 64, 17};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      tx_idle_pct  = tx_mix[p];
      rx_stall_pct = rx_mix[p];
      repeat (3) begin
        pick_region();
        send_page_cmd(CMD_INIT, 32'h0);
        run_traffic(51);
      end
    end
  endtask

  initial begin
    region_base_q = '0;
    page_count_q  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_corner_cases();
    test_random_traffic();
    wait_idle();
    // catch any stray beat after the last prediction was consumed
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("** bitmap_page_allocator_top: PASSED **");
    end else begin
      $display("** bitmap_page_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
